FILE: rtl/wfg_pkg.sv
// Shared types and constants for the wait-for-graph deadlock detector.
package wfg_pkg;

    localparam int THREADS_DEFAULT   = 16;
    localparam int RESOURCES_DEFAULT = 16;

    localparam int THREAD_W  = 4;
    localparam int RES_W     = 4;
    localparam int KIND_W    = 3;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] NUM_THREADS_RESET   = 5'd16;
    localparam logic [CFG_W-1:0] NUM_RESOURCES_RESET = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACQUIRE      = 3'd0,
        KIND_RELEASE      = 3'd1,
        KIND_WAIT_ON      = 3'd2,
        KIND_STOP_WAITING = 3'd3,
        KIND_CHECK        = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_THREADS   = 1'b0,
        CFG_NUM_RESOURCES = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_VISIT,
        ST_RD_WAIT,
        ST_RD_OWN,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/wfg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/wait_for_graph_deadlock_detector.sv
// Top level of the wait-for-graph deadlock detector.
//
// Input beats carry an event: acquire, release, wait_on, stop_waiting or check.
// The block raises in_stall while a check is in progress; update events are
// taken while no check runs, so updates can follow one another every cycle.
// A check walks, from every active thread, the chain thread -> awaited slot ->
// owning thread, one link at a time through the wait RAM and the owner RAM.
// Each visited thread passes through a mark, a wait read and an owner read,
// each start position is tested in turn, and a final start test ends the
// walk before the result register is loaded.
// Only a check gives a result beat, on out_valid with deadlock_found.
// The result sits in an output register; update events are still taken while
// it waits, and a second check can run but holds its answer until the
// receiver has taken the first one. A stalled result beat stays unchanged.
// Reset clears every owner and wait entry through valid bits, with no
// clearing pass, and sets both configuration registers to 16.
// Configuration writes on cfg_we take effect at once and are meant for idle.
module wait_for_graph_deadlock_detector #(
    parameter int THREADS   = wfg_pkg::THREADS_DEFAULT,
    parameter int RESOURCES = wfg_pkg::RESOURCES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [wfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wfg_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [wfg_pkg::KIND_W-1:0]     kind,
    input  logic [wfg_pkg::THREAD_W-1:0]   thread_num,
    input  logic [wfg_pkg::RES_W-1:0]      resource_num,
    input  logic                           bank_b,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           deadlock_found
);

    localparam int TW   = $clog2(THREADS);
    localparam int SCW  = $clog2(THREADS + 1);
    localparam int CW   = (SCW > wfg_pkg::CFG_W) ? SCW : wfg_pkg::CFG_W;
    localparam int SLOTS = 2 * RESOURCES;
    localparam int SW   = $clog2(SLOTS);
    localparam int RCB  = $clog2(RESOURCES + 1);
    localparam int RCW  = (RCB > wfg_pkg::CFG_W) ? RCB : wfg_pkg::CFG_W;

    localparam logic [CW-1:0]  THREADS_C   = CW'(THREADS);
    localparam logic [RCW-1:0] RESOURCES_C = RCW'(RESOURCES);
    localparam logic [SCW-1:0] STEPS_MAX   = SCW'(THREADS);

    wfg_pkg::state_t          state_reg, state_next;
    logic [wfg_pkg::CFG_W-1:0] num_threads_reg, num_threads_next;
    logic [wfg_pkg::CFG_W-1:0] num_resources_reg, num_resources_next;
    logic [SLOTS-1:0]         owner_valid_reg, owner_valid_next;
    logic [THREADS-1:0]       wait_valid_reg, wait_valid_next;
    logic [THREADS-1:0]       visited_reg, visited_next;
    logic [THREADS-1:0]       on_path_reg, on_path_next;
    logic [SCW-1:0]           start_reg, start_next;
    logic [TW-1:0]            cur_reg, cur_next;
    logic [SCW-1:0]           steps_reg, steps_next;
    logic                     found_reg, found_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     deadlock_found_reg, deadlock_found_next;

    logic [CW-1:0]  nt;
    logic [RCW-1:0] nr;
    logic           thr_ok;
    logic           res_ok;
    logic [TW-1:0]  thr_idx;
    logic [RCW:0]   slot_sum;
    logic [SW-1:0]  slot_in;
    logic [TW-1:0]  start_idx;
    logic [TW-1:0]  next_idx;
    logic           next_ok;
    logic           end_walk;

    logic                         own_we;
    logic [SW-1:0]                own_raddr;
    logic [wfg_pkg::THREAD_W-1:0] own_rdata;
    logic                         wait_we;
    logic [TW-1:0]                wait_raddr;
    logic [SW-1:0]                wait_rdata;

    wfg_ram #(
        .WIDTH(wfg_pkg::THREAD_W),
        .DEPTH(SLOTS)
    ) u_owner_ram (
        .clk  (clk),
        .we   (own_we),
        .waddr(slot_in),
        .wdata(thread_num),
        .raddr(own_raddr),
        .rdata(own_rdata)
    );

    wfg_ram #(
        .WIDTH(SW),
        .DEPTH(THREADS)
    ) u_wait_ram (
        .clk  (clk),
        .we   (wait_we),
        .waddr(thr_idx),
        .wdata(slot_in),
        .raddr(wait_raddr),
        .rdata(wait_rdata)
    );

    assign nt = (CW'(num_threads_reg) > THREADS_C) ? THREADS_C : CW'(num_threads_reg);
    assign nr = (RCW'(num_resources_reg) > RESOURCES_C) ? RESOURCES_C
                                                         : RCW'(num_resources_reg);
    assign thr_ok    = CW'(thread_num) < nt;
    assign res_ok    = RCW'(resource_num) < nr;
    assign thr_idx   = TW'(thread_num);
    assign slot_sum  = bank_b ? ((RCW + 1)'(nr) + (RCW + 1)'(resource_num))
                              : (RCW + 1)'(resource_num);
    assign slot_in   = SW'(slot_sum);
    assign start_idx = start_reg[TW-1:0];
    assign next_idx  = TW'(own_rdata);
    assign next_ok   = CW'(own_rdata) < THREADS_C;

    assign in_stall       = (state_reg != wfg_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign deadlock_found = deadlock_found_reg;
    assign wait_raddr     = cur_reg;
    assign own_raddr      = wait_rdata;

    always_comb
    begin
        state_next          = state_reg;
        num_threads_next    = num_threads_reg;
        num_resources_next  = num_resources_reg;
        owner_valid_next    = owner_valid_reg;
        wait_valid_next     = wait_valid_reg;
        visited_next        = visited_reg;
        on_path_next        = on_path_reg;
        start_next          = start_reg;
        cur_next            = cur_reg;
        steps_next          = steps_reg;
        found_next          = found_reg;
        out_valid_next      = out_valid_reg;
        deadlock_found_next = deadlock_found_reg;
        own_we              = 1'b0;
        wait_we             = 1'b0;
        end_walk            = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                wfg_pkg::CFG_NUM_THREADS:   num_threads_next   = cfg_data;
                wfg_pkg::CFG_NUM_RESOURCES: num_resources_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            wfg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind)
                        wfg_pkg::KIND_ACQUIRE:
                        begin
                            if (thr_ok && res_ok)
                            begin
                                own_we                    = 1'b1;
                                owner_valid_next[slot_in] = 1'b1;
                                wait_valid_next[thr_idx]  = 1'b0;
                            end
                        end
                        wfg_pkg::KIND_RELEASE:
                        begin
                            if (res_ok)
                            begin
                                owner_valid_next[slot_in] = 1'b0;
                            end
                        end
                        wfg_pkg::KIND_WAIT_ON:
                        begin
                            if (thr_ok && res_ok)
                            begin
                                wait_we                  = 1'b1;
                                wait_valid_next[thr_idx] = 1'b1;
                            end
                        end
                        wfg_pkg::KIND_STOP_WAITING:
                        begin
                            if (thr_ok)
                            begin
                                wait_valid_next[thr_idx] = 1'b0;
                            end
                        end
                        wfg_pkg::KIND_CHECK:
                        begin
                            visited_next = '0;
                            on_path_next = '0;
                            start_next   = '0;
                            state_next   = wfg_pkg::ST_START;
                        end
                        default: ;
                    endcase
                end
            end
            wfg_pkg::ST_START:
            begin
                if (!(CW'(start_reg) < nt))
                begin
                    found_next = 1'b0;
                    state_next = wfg_pkg::ST_DONE;
                end
                else if (visited_reg[start_idx])
                begin
                    start_next = start_reg + SCW'(1);
                end
                else
                begin
                    cur_next   = start_idx;
                    steps_next = '0;
                    state_next = wfg_pkg::ST_VISIT;
                end
            end
            wfg_pkg::ST_VISIT:
            begin
                visited_next[cur_reg] = 1'b1;
                on_path_next[cur_reg] = 1'b1;
                if (!wait_valid_reg[cur_reg])
                begin
                    end_walk = 1'b1;
                end
                else
                begin
                    state_next = wfg_pkg::ST_RD_WAIT;
                end
            end
            wfg_pkg::ST_RD_WAIT:
            begin
                if (!owner_valid_reg[wait_rdata])
                begin
                    end_walk = 1'b1;
                end
                else
                begin
                    state_next = wfg_pkg::ST_RD_OWN;
                end
            end
            wfg_pkg::ST_RD_OWN:
            begin
                if (!next_ok)
                begin
                    end_walk = 1'b1;
                end
                else if (on_path_reg[next_idx])
                begin
                    found_next = 1'b1;
                    state_next = wfg_pkg::ST_DONE;
                end
                else if (visited_reg[next_idx] || steps_reg == STEPS_MAX)
                begin
                    end_walk = 1'b1;
                end
                else
                begin
                    cur_next   = next_idx;
                    steps_next = steps_reg + SCW'(1);
                    state_next = wfg_pkg::ST_VISIT;
                end
            end
            wfg_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    deadlock_found_next = found_reg;
                    state_next          = wfg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wfg_pkg::ST_IDLE;
            end
        endcase

        if (end_walk)
        begin
            on_path_next = '0;
            start_next   = start_reg + SCW'(1);
            state_next   = wfg_pkg::ST_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= wfg_pkg::ST_IDLE;
            num_threads_reg    <= wfg_pkg::NUM_THREADS_RESET;
            num_resources_reg  <= wfg_pkg::NUM_RESOURCES_RESET;
            owner_valid_reg    <= '0;
            wait_valid_reg     <= '0;
            visited_reg        <= '0;
            on_path_reg        <= '0;
            start_reg          <= '0;
            cur_reg            <= '0;
            steps_reg          <= '0;
            found_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
            deadlock_found_reg <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            num_threads_reg    <= num_threads_next;
            num_resources_reg  <= num_resources_next;
            owner_valid_reg    <= owner_valid_next;
            wait_valid_reg     <= wait_valid_next;
            visited_reg        <= visited_next;
            on_path_reg        <= on_path_next;
            start_reg          <= start_next;
            cur_reg            <= cur_next;
            steps_reg          <= steps_next;
            found_reg          <= found_next;
            out_valid_reg      <= out_valid_next;
            deadlock_found_reg <= deadlock_found_next;
        end
    end

    // Every thread on the current path has also been visited.
    assert property (@(posedge clk) disable iff (!rst_n)
        (on_path_reg & ~visited_reg) == '0)
        else $error("on-path mark set on an unvisited thread");

    // A reported cycle always leaves the closing path marked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wfg_pkg::ST_DONE && found_reg) |-> on_path_reg != '0)
        else $error("deadlock reported with an empty path");

    // The walk never enters a thread it has already visited.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wfg_pkg::ST_VISIT |-> !visited_reg[cur_reg])
        else $error("walk revisits a thread");

    // Walks only start below the active thread count.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wfg_pkg::ST_VISIT && $past(state_reg) == wfg_pkg::ST_START
        |-> CW'(start_reg) < nt)
        else $error("walk started beyond the active threads");

endmodule
